// ----- rtl/aalr_pkg.sv -----
// Shared types and constants for the antialiased line rasterizer.
// Used by aalr_ctrl, aalr_dp and the top level; no dependencies.
`default_nettype none
package aalr_pkg;

    localparam int CoordW   = 9;    // Q.4 coordinate
    localparam int PixW     = 6;
    localparam int CovW     = 8;
    localparam int QuotW    = 17;   // gradient magnitude, Q.16
    localparam int YW       = 24;   // signed Q.16 row accumulator
    localparam int DivSteps = QuotW;

    typedef logic [CoordW-1:0] coord_t;

    localparam coord_t COORD_MAX = coord_t'(495);
    localparam logic [QuotW-1:0] GRAD_ONE = 17'h10000;

    typedef struct packed {
        logic load;
        logic div_step;
        logic set1;
        logic set2;
        logic lset;
        logic step;
        logic emit;
        logic half;
        logic last;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic loop_empty;
        logic col_last;
    } stat_t;

    function automatic coord_t sat_coord(input coord_t v);
        return (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/antialiased_line_rasterizer_unit.sv -----
// Wu antialiased line rasterizer: one segment in, 4 + 2*(inner columns) pixels out.
// First pixel word: the accept is followed by the divide steps, the endpoint setup and
// the emit into the output word register. Intake stays closed until the last pixel word
// is emitted. The bit-per-cycle divider and one word per free output cycle set the pace.
// Reset (rst_n low, async) returns the sequencer to idle and drops m_axis_tvalid.
// Depends on aalr_pkg, aalr_ctrl, aalr_dp.
`default_nettype none
module antialiased_line_rasterizer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // start_x, start_y, end_x, end_y, pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // pixel_x, pixel_y, coverage, pad
    output logic             m_axis_tlast
);
    import aalr_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [PixW-1:0] pixel_x, pixel_y;
    logic [CovW-1:0] coverage;

    aalr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    aalr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .start_x    (s_axis_tdata[8:0]),
        .start_y    (s_axis_tdata[17:9]),
        .end_x      (s_axis_tdata[26:18]),
        .end_y      (s_axis_tdata[35:27]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .coverage   (coverage),
        .last_pixel (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0, coverage, pixel_y, pixel_x};

`ifndef NO_ASSERTIONS
    // a segment blocks intake until its pixels are all produced
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a segment is in progress");

    // a non-final word means more pixels of the same segment remain
    a_mid_segment: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("sequencer idle with segment unfinished");

    // emission only while the output stage can take a word
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && stat.out_free |=> m_axis_tvalid)
        else $error("emitted pixel word lost");
`endif

endmodule
`default_nettype wire

// ----- rtl/aalr_ctrl.sv -----
// Sequencer for the rasterizer: divide, endpoint setup, pixel emission.
// Depends on aalr_pkg; drives aalr_dp through cmd_t and reads stat_t.
`default_nettype none
module aalr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output aalr_pkg::cmd_t      cmd,
    input  wire aalr_pkg::stat_t stat
);
    import aalr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SET1 = 3'd2;
    localparam logic [2:0] S_EM1  = 3'd3;
    localparam logic [2:0] S_SET2 = 3'd4;
    localparam logic [2:0] S_EM2  = 3'd5;
    localparam logic [2:0] S_LSET = 3'd6;
    localparam logic [2:0] S_LOOP = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       half_reg, half_next;
    logic [4:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        half_next  = half_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.half   = half_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    half_next  = 1'b0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DivSteps - 1))
                    state_next = S_SET1;
            end
            S_SET1:
            begin
                cmd.set1   = 1'b1;
                state_next = S_EM1;
            end
            S_EM1:
            begin
                cmd.emit = 1'b1;
                if (stat.out_free)
                begin
                    half_next = ~half_reg;
                    if (half_reg)
                        state_next = S_SET2;
                end
            end
            S_SET2:
            begin
                cmd.set2   = 1'b1;
                state_next = S_EM2;
            end
            S_EM2:
            begin
                cmd.emit = 1'b1;
                cmd.last = half_reg & stat.loop_empty;
                if (stat.out_free)
                begin
                    half_next = ~half_reg;
                    if (half_reg)
                        state_next = stat.loop_empty ? S_IDLE : S_LSET;
                end
            end
            S_LSET:
            begin
                cmd.lset   = 1'b1;
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                cmd.emit = 1'b1;
                cmd.last = half_reg & stat.col_last;
                if (stat.out_free)
                begin
                    half_next = ~half_reg;
                    if (half_reg)
                    begin
                        if (stat.col_last)
                            state_next = S_IDLE;
                        else
                            cmd.step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            half_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/aalr_dp.sv -----
// Datapath: endpoint ordering, restoring gradient divider, row accumulator,
// coverage multiply and the output word register. Depends on aalr_pkg.
`default_nettype none
module aalr_dp (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire aalr_pkg::coord_t        start_x,
    input  wire aalr_pkg::coord_t        start_y,
    input  wire aalr_pkg::coord_t        end_x,
    input  wire aalr_pkg::coord_t        end_y,
    input  wire aalr_pkg::cmd_t          cmd,
    output aalr_pkg::stat_t              stat,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [aalr_pkg::PixW-1:0]    pixel_x,
    output logic [aalr_pkg::PixW-1:0]    pixel_y,
    output logic [aalr_pkg::CovW-1:0]    coverage,
    output logic                         last_pixel
);
    import aalr_pkg::*;

    // input ordering
    coord_t sx, sy, ex, ey, adx, ady_in, a0, b0, a1, b1;
    coord_t lx0, ly0, lx1, ly1, ady;
    logic   steep, swp;
    logic [CoordW:0] dy;

    always_comb
    begin
        sx     = sat_coord(start_x);
        sy     = sat_coord(start_y);
        ex     = sat_coord(end_x);
        ey     = sat_coord(end_y);
        adx    = (ex > sx) ? ex - sx : sx - ex;
        ady_in = (ey > sy) ? ey - sy : sy - ey;
        steep  = ady_in > adx;
        a0     = steep ? sy : sx;
        b0     = steep ? sx : sy;
        a1     = steep ? ey : ex;
        b1     = steep ? ex : ey;
        swp    = a0 > a1;
        lx0    = swp ? a1 : a0;
        ly0    = swp ? b1 : b0;
        lx1    = swp ? a0 : a1;
        ly1    = swp ? b0 : b1;
        dy     = {1'b0, ly1} - {1'b0, ly0};
        ady    = dy[CoordW] ? coord_t'(-dy) : dy[CoordW-1:0];
    end

    logic             steep_reg, neg_reg;
    coord_t           x0_reg, y0_reg, x1_reg, y1_reg, dx_reg;
    logic [CoordW:0]  rem_reg;
    logic [QuotW-1:0] q_reg;
    logic [4:0]       col_reg;
    logic signed [YW-1:0] cury_reg, intery_reg;
    logic [4:0]       w4_reg;

    // divider step
    logic             ge;
    logic [CoordW:0]  r2;
    assign ge = rem_reg >= {1'b0, dx_reg};
    assign r2 = ge ? rem_reg - {1'b0, dx_reg} : rem_reg;

    // gradient, Q.16 signed
    logic [QuotW-1:0]      gmag;
    logic signed [QuotW:0] grad;
    assign gmag = (dx_reg == '0) ? GRAD_ONE : q_reg;
    assign grad = neg_reg ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});

    // endpoint columns
    logic [CoordW:0] s1, s2;
    logic [4:0]      xe1, xe2;
    assign s1  = {1'b0, x0_reg} + 10'd8;
    assign s2  = {1'b0, x1_reg} + 10'd8;
    assign xe1 = s1[8:4];
    assign xe2 = s2[8:4];

    // yend = y + floor(grad * (xe*16 - x) / 16), one shared multiplier
    logic signed [CoordW:0]     dsel;
    coord_t                     ysel;
    logic signed [QuotW+CoordW+1:0] prod;
    logic signed [YW-1:0]       yend, gext;
    always_comb
    begin
        if (cmd.set2)
        begin
            dsel = $signed({1'b0, xe2, 4'b0}) - $signed({1'b0, x1_reg});
            ysel = y1_reg;
        end
        else
        begin
            dsel = $signed({1'b0, xe1, 4'b0}) - $signed({1'b0, x0_reg});
            ysel = y0_reg;
        end
        prod = grad * dsel;
        yend = $signed({3'b0, ysel, 12'b0}) + $signed(prod[YW+3:4]);
        gext = YW'(grad);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            steep_reg <= steep;
            x0_reg    <= lx0;
            y0_reg    <= ly0;
            x1_reg    <= lx1;
            y1_reg    <= ly1;
            dx_reg    <= lx1 - lx0;
            neg_reg   <= dy[CoordW];
            rem_reg   <= {1'b0, ady};
            q_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= {r2[CoordW-1:0], 1'b0};
            q_reg   <= {q_reg[QuotW-2:0], ge};
        end
        if (cmd.set1)
        begin
            cury_reg   <= yend;
            intery_reg <= yend + gext;
            col_reg    <= xe1;
            w4_reg     <= 5'd16 - {1'b0, s1[3:0]};
        end
        else if (cmd.set2)
        begin
            cury_reg <= yend;
            col_reg  <= xe2;
            w4_reg   <= {1'b0, s2[3:0]};
        end
        else if (cmd.lset)
        begin
            cury_reg <= intery_reg;
            col_reg  <= xe1 + 5'd1;
            w4_reg   <= 5'd16;
        end
        else if (cmd.step)
        begin
            cury_reg <= cury_reg + gext;
            col_reg  <= col_reg + 5'd1;
        end
    end

    always_comb
    begin
        stat.out_free   = !out_valid || out_ready;
        stat.loop_empty = {1'b0, xe2} < ({1'b0, xe1} + 6'd2);
        stat.col_last   = col_reg == (xe2 - 5'd1);
    end

    // pixel word
    logic [16:0]      a;
    logic [21:0]      p;
    logic [CovW-1:0]  cov;
    logic [PixW-1:0]  row, colw;
    always_comb
    begin
        a    = cmd.half ? {1'b0, cury_reg[15:0]} : GRAD_ONE - {1'b0, cury_reg[15:0]};
        p    = a * w4_reg;
        cov  = (p[21:12] > 10'd255) ? 8'hFF : p[19:12];
        row  = cury_reg[21:16] + {5'b0, cmd.half};
        colw = {1'b0, col_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.emit && stat.out_free)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit && stat.out_free)
        begin
            pixel_x    <= steep_reg ? row : colw;
            pixel_y    <= steep_reg ? colw : row;
            coverage   <= cov;
            last_pixel <= cmd.last;
        end
    end

endmodule
`default_nettype wire

// ----- verif/tb_antialiased_line_rasterizer_unit.sv -----
// Testbench for antialiased_line_rasterizer_unit: drives segments, predicts Wu pixels.
// Depends on aalr_pkg and the RTL top level; self-checking, no external files.
`default_nettype none
module tb_antialiased_line_rasterizer_unit;
    import aalr_pkg::*;

    localparam int NumRandom  = 300;
    localparam int WatchLimit = 20000;
    localparam int DrainWait  = 200;
    localparam int MaxFrac    = ((32 - 1) << 4) - 1;

    typedef struct packed {
        logic [5:0] px;
        logic [5:0] py;
        logic [7:0] cov;
        logic       last;
    } pixel_t;

    typedef struct {
        logic [8:0] sx, sy, ex, ey;
        logic       typed;      // expected pixels below are typed in
        int         n_typed;
        pixel_t     pix [4];
    } seg_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    pixel_t expected_pixels[$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_recv = 1'b0;
    seg_row_t seg_table[$];

    antialiased_line_rasterizer_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    function automatic longint floor_q16(longint v);
        if (v >= 0)
            return v >>> 16;
        return -((-v + 65535) >>> 16);
    endfunction

    function automatic logic [7:0] wu_cover(longint a, longint b);
        longint unsigned c;
        c = ((longint'(a) * longint'(b)) << 8) >> 32;
        return (c > 255) ? 8'd255 : c[7:0];
    endfunction

    function automatic longint to_q16(logic [8:0] v);
        longint t;
        t = v;
        if (t > MaxFrac)
            t = MaxFrac;
        return t << 12;
    endfunction

    // Pixel pair at one column: row ipart(y) and the row below it.
    task automatic push_pair(bit steep, longint col, longint y, longint w);
        longint f, iy, r;
        pixel_t p;
        f  = y - floor_q16(y) * 65536;
        iy = floor_q16(y);
        for (int k = 0; k < 2; k++)
        begin
            r = iy + k;
            p.px   = steep ? r[5:0] : col[5:0];
            p.py   = steep ? col[5:0] : r[5:0];
            p.cov  = wu_cover(k == 0 ? 65536 - f : f, w);
            p.last = 1'b0;
            expected_pixels.push_back(p);
        end
    endtask

    task automatic predict_segment(logic [8:0] sx, sy, ex, ey);
        longint x0, y0, x1, y1, t, dx, dy, grad, xe1, xe2, ye, intery, adx, ady;
        bit steep;
        pixel_t p;
        x0 = to_q16(sx); y0 = to_q16(sy); x1 = to_q16(ex); y1 = to_q16(ey);
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        steep = ady > adx;
        if (steep)
        begin
            t = x0; x0 = y0; y0 = t;
            t = x1; x1 = y1; y1 = t;
        end
        if (x0 > x1)
        begin
            t = x0; x0 = x1; x1 = t;
            t = y0; y0 = y1; y1 = t;
        end
        dx = x1 - x0;
        dy = y1 - y0;
        if (dx == 0)
            grad = 65536;
        else
        begin
            grad = ((dy < 0 ? -dy : dy) << 16) / dx;
            if (dy < 0)
                grad = -grad;
        end
        xe1 = floor_q16(x0 + 32768);
        ye  = y0 + floor_q16(grad * (xe1 * 65536 - x0));
        push_pair(steep, xe1, ye, 65536 - ((x0 + 32768) - xe1 * 65536));
        intery = ye + grad;
        xe2 = floor_q16(x1 + 32768);
        ye  = y1 + floor_q16(grad * (xe2 * 65536 - x1));
        push_pair(steep, xe2, ye, (x1 + 32768) - xe2 * 65536);
        for (longint c = xe1 + 1; c <= xe2 - 1; c++)
        begin
            push_pair(steep, c, intery, 65536);
            intery += grad;
        end
        p = expected_pixels.pop_back();
        p.last = 1'b1;
        expected_pixels.push_back(p);
    endtask

    function automatic bit rand_pct(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // tvalid stays up after a word is taken until a drain or an idle gap in the next call lowers it
    task automatic send_segment(logic [8:0] sx, sy, ex, ey);
        while (rand_pct(send_idle_pct))
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= {4'b0, ey, ex, sy, sx};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [8:0] rand_coord();
        case ($urandom_range(9, 0))
            0: return 9'd0;
            1: return 9'($urandom_range(511, 496));   // saturates
            2: return 9'd495;
            3: return 9'($urandom_range(511, 0));
            default: return 9'($urandom_range(120, 0));  // short segments mostly
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold when asked.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_recv && !rand_pct(recv_stall_pct);
    end

    always @(posedge clk)
    begin
        pixel_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[5:0], m_axis_tdata[11:6], m_axis_tdata[19:12], m_axis_tlast};
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pixel word %h last %b", m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"pixel mismatch: exp x=%0d y=%0d cov=%0d last=%b, ",
                                  "got x=%0d y=%0d cov=%0d last=%b"},
                                 want.px, want.py, want.cov, want.last,
                                 got.px, got.py, got.cov, got.last);
                end
            end
        end
    end

    // Watchdog: cycles with no word accepted on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic add_row(logic [8:0] sx, sy, ex, ey, bit typed = 0, logic [7:0] c0 = 0);
        seg_row_t r;
        r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
        r.typed = typed;
        r.n_typed = 0;
        if (typed)
        begin
            // degenerate point on whole coordinates: both endpoints get gap 0.5
            r.n_typed = 4;
            r.pix[0] = '{sx[8:4] + 6'(sx[3]), 6'(sy[8:4]), c0, 1'b0};
            r.pix[1] = '{sx[8:4] + 6'(sx[3]), 6'(sy[8:4]) + 6'd1, 8'd0, 1'b0};
            r.pix[2] = '{sx[8:4] + 6'(sx[3]), 6'(sy[8:4]), c0, 1'b0};
            r.pix[3] = '{sx[8:4] + 6'(sx[3]), 6'(sy[8:4]) + 6'd1, 8'd0, 1'b1};
        end
        seg_table.push_back(r);
    endtask

    initial
    begin
        logic [8:0] a, b, c, d;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: degenerate points (gap 0.5 -> upper pixel of each pair 128, lower 0).
        add_row(9'd0, 9'd0, 9'd0, 9'd0, 1, 8'd128);
        add_row(9'd160, 9'd160, 9'd160, 9'd160, 1, 8'd128);
        add_row(9'd511, 9'd511, 9'd511, 9'd511);          // saturated point
        add_row(9'd0, 9'd0, 9'd495, 9'd495);              // full diagonal
        add_row(9'd495, 9'd0, 9'd0, 9'd495);              // anti-diagonal
        add_row(9'd0, 9'd100, 9'd495, 9'd100);            // flat, longest
        add_row(9'd100, 9'd0, 9'd100, 9'd495);            // vertical, steep
        add_row(9'd300, 9'd40, 9'd20, 9'd90);             // reversed x
        add_row(9'd3, 9'd1, 9'd200, 9'd2);                // shallow, y near row 0
        add_row(9'd7, 9'd9, 9'd400, 9'd300);
        add_row(9'd256, 9'd170, 9'd85, 9'd341);           // toggling bits
        add_row(9'd170, 9'd341, 9'd256, 9'd85);
        add_row(9'd511, 9'd0, 9'd0, 9'd511);
        add_row(9'd8, 9'd8, 9'd24, 9'd9);
        foreach (seg_table[i])
        begin
            if (seg_table[i].typed)
                for (int k = 0; k < seg_table[i].n_typed; k++)
                    expected_pixels.push_back(seg_table[i].pix[k]);
            else
                predict_segment(seg_table[i].sx, seg_table[i].sy,
                                seg_table[i].ex, seg_table[i].ey);
            send_segment(seg_table[i].sx, seg_table[i].sy, seg_table[i].ex, seg_table[i].ey);
        end
        wait_drained();

        // Long receiver hold while the sender keeps offering words.
        hold_recv = 1'b1;
        fork
            begin
                repeat (600) @(negedge clk);
                hold_recv = 1'b0;
            end
            for (int i = 0; i < 6; i++)
            begin
                a = rand_coord(); b = rand_coord(); c = rand_coord(); d = rand_coord();
                predict_segment(a, b, c, d);
                send_segment(a, b, c, d);
            end
        join
        wait_drained();

        for (int i = 0; i < NumRandom; i++)
        begin
            case (i * 4 / NumRandom)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 76; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct = 14; recv_stall_pct = 14;
                end
            endcase
            a = rand_coord(); b = rand_coord(); c = rand_coord(); d = rand_coord();
            predict_segment(a, b, c, d);
            send_segment(a, b, c, d);
        end
        wait_drained();
        repeat (DrainWait) @(negedge clk);

        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire
